>>> hw/rtl/sensor_window_average_calibrate_assert.svh
// Assertion macros shared by the sensor window average RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef SENSOR_WINDOW_AVERAGE_CALIBRATE_ASSERT_SVH
`define SENSOR_WINDOW_AVERAGE_CALIBRATE_ASSERT_SVH

// Overlapping implication, checked at every rising edge outside reset
`define SWAC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define SWAC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/swac_pkg.sv
// Package for the sensor window average: constants, register codes, shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package swac_pkg;

  // Sample path
  localparam int ADC_BITS    = 10;
  localparam int ADC_FULL    = 1 << ADC_BITS;
  localparam int SAMPLE_W    = ADC_BITS + 1;
  localparam int WINDOW_LEN  = 32;
  localparam int SLOT_W      = $clog2(WINDOW_LEN);
  localparam int SUM_W       = 16;
  localparam int MEAN_SHIFT  = 5;
  localparam int OVER_SHIFT  = 3;
  localparam int MEAN_W      = SUM_W - MEAN_SHIFT;
  localparam int OVER_W      = SUM_W - OVER_SHIFT;

  // Calibration
  localparam int COEFF_SHIFT = 8;
  localparam int CAL_DIVISOR = 1 << COEFF_SHIFT;
  localparam int GAIN_W      = 17;
  localparam int OFFSET_W    = 25;
  localparam int LIMIT_W     = 11;
  localparam int ACC_W       = 31;
  localparam int TEMP_W      = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = OFFSET_W;

  // Register reset values
  localparam int GAIN_RESET   = 256;
  localparam int OFFSET_RESET = 0;
  localparam int ABSENT_RESET = 50;
  localparam int SHORT_RESET  = 1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAL_GAIN     = 4'd0,
    REG_CAL_OFFSET   = 4'd1,
    REG_ABSENT_LIMIT = 4'd2,
    REG_SHORT_LIMIT  = 4'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ABSENT  = 2'd1,
    STATUS_SHORTED = 2'd2
  } status_t;

  // Calibration register file contents
  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [OFFSET_W-1:0] offset;
    logic [LIMIT_W-1:0]  absent_limit;
    logic [LIMIT_W-1:0]  short_limit;
  } cfg_t;

  // Window sum stage handed from the ring to the calibration stage
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } sum_stage_t;

endpackage

>>> hw/rtl/swac_cfg.sv
// Calibration register file with its write channel.
// Depends on swac_pkg.
`timescale 1ns / 1ps

module swac_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [swac_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [swac_pkg::CFG_DATA_W-1:0]    cfg_data,
  output swac_pkg::cfg_t                     cfg
);

  // Always ready; every write is taken without a stall
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain         <= swac_pkg::GAIN_W'(swac_pkg::GAIN_RESET);
      cfg.offset       <= swac_pkg::OFFSET_W'(swac_pkg::OFFSET_RESET);
      cfg.absent_limit <= swac_pkg::LIMIT_W'(swac_pkg::ABSENT_RESET);
      cfg.short_limit  <= swac_pkg::LIMIT_W'(swac_pkg::SHORT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swac_pkg::REG_CAL_GAIN:     cfg.gain         <= cfg_data[swac_pkg::GAIN_W-1:0];
        swac_pkg::REG_CAL_OFFSET:   cfg.offset       <= cfg_data[swac_pkg::OFFSET_W-1:0];
        swac_pkg::REG_ABSENT_LIMIT: cfg.absent_limit <= cfg_data[swac_pkg::LIMIT_W-1:0];
        swac_pkg::REG_SHORT_LIMIT:  cfg.short_limit  <= cfg_data[swac_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/swac_ring.sv
// Sample ring, running window sum and the input stage register.
// Depends on swac_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sensor_window_average_calibrate_assert.svh"

module swac_ring (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  logic [swac_pkg::ADC_BITS-1:0]    raw_sample,
  input  logic                             stage_take,
  output swac_pkg::sum_stage_t             stage
);

  localparam logic [swac_pkg::SLOT_W-1:0] LAST_SLOT =
    swac_pkg::SLOT_W'(swac_pkg::WINDOW_LEN - 1);

  logic [swac_pkg::SAMPLE_W-1:0] ring [swac_pkg::WINDOW_LEN];
  logic [swac_pkg::SLOT_W-1:0]   slot;
  logic [swac_pkg::SUM_W-1:0]    sum;
  logic [swac_pkg::SUM_W-1:0]    sum_next;
  logic [swac_pkg::SAMPLE_W-1:0] inverted;
  logic                          accept;

  assign sample_ready = !stage.valid || stage_take;
  assign accept       = sample_valid && sample_ready;

  // Invert the code and swap it into the window sum
  assign inverted = swac_pkg::SAMPLE_W'(swac_pkg::ADC_FULL) -
                    swac_pkg::SAMPLE_W'(raw_sample);
  assign sum_next = sum - swac_pkg::SUM_W'(ring[slot]) + swac_pkg::SUM_W'(inverted);

  // Ring, sum and write slot; the slot walks downward
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < swac_pkg::WINDOW_LEN; i++) begin
        ring[i] <= '0;
      end
      sum  <= '0;
      slot <= LAST_SLOT;
    end else if (accept) begin
      ring[slot] <= inverted;
      sum        <= sum_next;
      slot       <= (slot == '0) ? LAST_SLOT : slot - 1'b1;
    end
  end

  // Stage register toward the calibration logic
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (sample_ready) begin
      stage.valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.sum <= sum_next;
    end
  end

  `SWAC_ASSERT_NXT(a_sum_holds, clk, rst, !accept, $stable(sum),
    "window sum changed without a sample transaction")
  `SWAC_ASSERT_NXT(a_slot_walk, clk, rst, accept,
    slot == (($past(slot) == '0) ? LAST_SLOT : $past(slot) - 1'b1),
    "write slot did not step down after a sample transaction")
  `SWAC_ASSERT_NXT(a_stage_loaded, clk, rst, accept,
    stage.valid && stage.sum == $past(sum_next),
    "stage register missed an accepted sample")

endmodule

>>> hw/rtl/swac_calc.sv
// Mean, oversampled value, sensor status and calibrated temperature,
// with the result register. Depends on swac_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sensor_window_average_calibrate_assert.svh"

module swac_calc (
  input  logic                              clk,
  input  logic                              rst,
  input  swac_pkg::cfg_t                    cfg,
  input  swac_pkg::sum_stage_t              stage,
  output logic                              stage_take,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [swac_pkg::MEAN_W-1:0]       window_mean,
  output logic [swac_pkg::OVER_W-1:0]       oversampled,
  output logic [1:0]                        sensor_status,
  output logic signed [swac_pkg::TEMP_W-1:0] temperature
);

  logic [swac_pkg::MEAN_W-1:0]        mean;
  logic [swac_pkg::OVER_W-1:0]        over;
  swac_pkg::status_t                  status;
  logic signed [swac_pkg::ACC_W-1:0]  prod;
  logic signed [swac_pkg::ACC_W-1:0]  acc;
  logic signed [swac_pkg::ACC_W-1:0]  biased;
  logic [swac_pkg::TEMP_W-1:0]        temp;

  // Result register is free or being drained this cycle
  assign stage_take = !result_valid || result_ready;

  assign mean = stage.sum[swac_pkg::SUM_W-1:swac_pkg::MEAN_SHIFT];
  assign over = stage.sum[swac_pkg::SUM_W-1:swac_pkg::OVER_SHIFT];

  // Absent test wins when both limits trip
  always_comb begin
    if (swac_pkg::LIMIT_W'(mean) < cfg.absent_limit) begin
      status = swac_pkg::STATUS_ABSENT;
    end else if (swac_pkg::LIMIT_W'(mean) > cfg.short_limit) begin
      status = swac_pkg::STATUS_SHORTED;
    end else begin
      status = swac_pkg::STATUS_OK;
    end
  end

  // mean * gain + offset, then divide by the scale rounding toward zero
  assign prod   = swac_pkg::ACC_W'($signed({1'b0, mean})) *
                  swac_pkg::ACC_W'($signed(cfg.gain));
  assign acc    = prod + swac_pkg::ACC_W'($signed(cfg.offset));
  assign biased = acc + (acc[swac_pkg::ACC_W-1] ?
                         swac_pkg::ACC_W'(swac_pkg::CAL_DIVISOR - 1) : '0);
  assign temp   = biased[swac_pkg::COEFF_SHIFT + swac_pkg::TEMP_W - 1:swac_pkg::COEFF_SHIFT];

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_take) begin
      result_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && stage.valid) begin
      window_mean   <= mean;
      oversampled   <= over;
      sensor_status <= status;
      temperature   <= temp;
    end
  end

  `SWAC_ASSERT_IMP(a_absent_code, clk, rst,
    result_valid && sensor_status == swac_pkg::STATUS_ABSENT,
    swac_pkg::LIMIT_W'(window_mean) < cfg.absent_limit,
    "absent status with mean at or above the absent limit")
  `SWAC_ASSERT_IMP(a_shorted_code, clk, rst,
    result_valid && sensor_status == swac_pkg::STATUS_SHORTED,
    swac_pkg::LIMIT_W'(window_mean) > cfg.short_limit &&
    !(swac_pkg::LIMIT_W'(window_mean) < cfg.absent_limit),
    "shorted status without the short limit tripped alone")
  `SWAC_ASSERT_NXT(a_stage_moves, clk, rst, stage.valid && stage_take,
    result_valid && window_mean == $past(mean),
    "stage transaction did not reach the result register")

endmodule

>>> hw/rtl/sensor_window_average_calibrate.sv
// Sensor window average with linear calibration, top level.
// Latency: two register stages; a sample passes the stage register and then the
// result register, and either can hold it while result_ready is low.
// Throughput: one sample per cycle while result_ready is high; the ring write, sum
// update and one multiply-add each fit between two registers.
// Reset: clears the 32-entry ring, the sum and both stage valids,
// loads the calibration defaults; no clearing pass follows.
`timescale 1ns / 1ps

module sensor_window_average_calibrate (
  input  logic                                clk,
  input  logic                                rst,
  // Sample channel
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic [swac_pkg::ADC_BITS-1:0]       raw_sample,
  // Result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [swac_pkg::MEAN_W-1:0]         window_mean,
  output logic [swac_pkg::OVER_W-1:0]         oversampled,
  output logic [1:0]                          sensor_status,
  output logic signed [swac_pkg::TEMP_W-1:0]  temperature,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swac_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [swac_pkg::CFG_DATA_W-1:0]     cfg_data
);

  swac_pkg::cfg_t       cfg;
  swac_pkg::sum_stage_t stage;
  logic                 stage_take;

  // Calibration registers
  swac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Ring and running sum
  swac_ring u_ring (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .raw_sample   (raw_sample),
    .stage_take   (stage_take),
    .stage        (stage)
  );

  // Mean, status and temperature
  swac_calc u_calc (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .stage         (stage),
    .stage_take    (stage_take),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .window_mean   (window_mean),
    .oversampled   (oversampled),
    .sensor_status (sensor_status),
    .temperature   (temperature)
  );

endmodule
